/* rtl/psx_pkg.sv */
`default_nettype none

package psx_pkg;

	// Printable range is exclusive at both ends: codes 33 to 126.
	localparam logic [7:0] PRINT_LOW  = 8'd32;
	localparam logic [7:0] PRINT_HIGH = 8'd127;
	localparam logic [7:0] NEWLINE    = 8'h0A;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STRINGS = 1'b1;
	localparam logic [4:0]  MIN_LENGTH_RST  = 5'd3;
	localparam logic [15:0] MAX_STRINGS_RST = 16'hFFFF;

	// Sequencer states: taking bytes, draining the hold memory, sending the
	// byte that qualified the run, sending a closing newline.
	typedef enum logic [1:0] {
		S_IDLE,
		S_FLUSH,
		S_BYTE,
		S_NL
	} psx_state_t;

endpackage

`default_nettype wire

/* rtl/psx_in_if.sv */
`default_nettype none

interface psx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, in_byte, end_of_stream, input ready);
	modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

`default_nettype wire

/* rtl/psx_out_if.sv */
`default_nettype none

interface psx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_burst;

	modport source (output valid, out_byte, last_of_burst, input ready);
	modport sink (input valid, out_byte, last_of_burst, output ready);
endinterface

`default_nettype wire

/* rtl/printable_string_extractor.sv */
// A passed-through byte or newline appears on the output in the cycle after its request is taken.
// Throughput: one byte per cycle while bytes are held or passed straight through and the output is not stalled.
// A qualifying byte that flushes N held bytes blocks intake while the N held bytes
// pass through the single read port of the hold memory and the one output register.
// Reset (arst_n low, asynchronous) clears the run state, the string count and the
// output register, and restores min_length 3 and max_strings 65535.
`default_nettype none

module printable_string_extractor
	import psx_pkg::*;
#(
	parameter int unsigned HOLD_DEPTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	psx_in_if.sink                    scan,
	psx_out_if.source                 emit
);

	localparam int unsigned LW = $clog2(HOLD_DEPTH);
	localparam logic [LW-1:0] THR_MAX = LW'(HOLD_DEPTH - 1);

	psx_state_t state_q, state_d;

	logic [4:0]    min_len_q;
	logic [15:0]   max_str_q;
	logic [LW-1:0] run_len_q;
	logic          qual_q;
	logic          supp_q;
	logic [15:0]   cnt_q;

	logic [7:0]    hold_mem [HOLD_DEPTH];
	logic [LW-1:0] flush_len_q;
	logic [LW-1:0] rd_addr_q;
	logic          rd_vld_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    held_byte_q;
	logic          eos_q;

	logic          o_vld_q;
	logic [7:0]    o_byte_q;
	logic          o_last_q;

	logic          o_free, acc;
	logic [LW-1:0] thr;
	logic          printable, qualify, has_room;
	logic          pass_now, flush_go, nl_now, mem_we;
	logic          rd_issue, consume, o_load, o_last_d;
	logic [7:0]    o_byte_d;

	// Effective threshold, limited by what the hold memory can keep.
	always_comb begin
		if (32'(min_len_q) > 32'(THR_MAX)) begin
			thr = THR_MAX;
		end else begin
			thr = LW'(min_len_q);
		end
	end

	assign o_free     = !o_vld_q || emit.ready;
	assign scan.ready = (state_q == S_IDLE) && o_free;
	assign acc        = scan.valid && scan.ready;

	// Classification of the incoming byte against the run state.
	assign printable = (scan.in_byte > PRINT_LOW) && (scan.in_byte < PRINT_HIGH);
	assign qualify   = printable && !qual_q && (run_len_q >= thr);
	assign has_room  = cnt_q < max_str_q;
	assign pass_now  = printable && ((qual_q && !supp_q) ||
		(qualify && has_room && (run_len_q == '0)));
	assign flush_go  = qualify && has_room && (run_len_q != '0);
	assign nl_now    = !printable && qual_q && !supp_q;
	assign mem_we    = acc && printable && !qual_q && (run_len_q < thr);

	// Next state and output register loading.
	always_comb begin
		state_d  = state_q;
		o_load   = 1'b0;
		o_byte_d = scan.in_byte;
		o_last_d = 1'b0;
		rd_issue = 1'b0;
		consume  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (pass_now) begin
						o_load   = 1'b1;
						o_last_d = !scan.end_of_stream;
						if (scan.end_of_stream) begin
							state_d = S_NL;
						end
					end else if (flush_go) begin
						state_d = S_FLUSH;
					end else if (nl_now) begin
						o_load   = 1'b1;
						o_byte_d = NEWLINE;
						o_last_d = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				consume  = rd_vld_q && o_free;
				rd_issue = (rd_addr_q != flush_len_q) && (!rd_vld_q || consume);
				if (consume) begin
					o_load   = 1'b1;
					o_byte_d = rd_data_q;
				end
				if ((rd_addr_q == flush_len_q) && (!rd_vld_q || consume)) begin
					state_d = S_BYTE;
				end
			end
			S_BYTE: begin
				if (o_free) begin
					o_load   = 1'b1;
					o_byte_d = held_byte_q;
					o_last_d = !eos_q;
					state_d  = eos_q ? S_NL : S_IDLE;
				end
			end
			S_NL: begin
				if (o_free) begin
					o_load   = 1'b1;
					o_byte_d = NEWLINE;
					o_last_d = 1'b1;
					state_d  = S_IDLE;
				end
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LENGTH_RST;
			max_str_q <= MAX_STRINGS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_LENGTH:  min_len_q <= cfg_data[4:0];
				REG_MAX_STRINGS: max_str_q <= cfg_data;
			endcase
		end
	end

	// Run state; the stream end clears everything after the byte is handled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
			qual_q    <= 1'b0;
			supp_q    <= 1'b0;
			cnt_q     <= '0;
		end else if (acc) begin
			if (scan.end_of_stream) begin
				run_len_q <= '0;
				qual_q    <= 1'b0;
				supp_q    <= 1'b0;
				cnt_q     <= '0;
			end else if (!printable) begin
				run_len_q <= '0;
				qual_q    <= 1'b0;
				supp_q    <= 1'b0;
			end else if (qualify) begin
				qual_q <= 1'b1;
				if (has_room) begin
					supp_q <= 1'b0;
					cnt_q  <= cnt_q + 16'd1;
				end else begin
					supp_q <= 1'b1;
				end
			end else if (!qual_q) begin
				run_len_q <= run_len_q + LW'(1);
			end
		end
	end

	// Flush read pointer and read-data valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_vld_q  <= 1'b0;
		end else if (acc && flush_go) begin
			rd_addr_q <= '0;
			rd_vld_q  <= 1'b0;
		end else if (rd_issue) begin
			rd_addr_q <= rd_addr_q + LW'(1);
			rd_vld_q  <= 1'b1;
		end else if (consume) begin
			rd_vld_q <= 1'b0;
		end
	end

	// Hold memory: written while a run is short, read back during a flush.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hold_mem[run_len_q] <= scan.in_byte;
		end
		if (rd_issue) begin
			rd_data_q <= hold_mem[rd_addr_q];
		end
	end

	// Snapshot of the request that starts a flush.
	always_ff @(posedge clk) begin
		if (acc && flush_go) begin
			flush_len_q <= run_len_q;
			held_byte_q <= scan.in_byte;
			eos_q       <= scan.end_of_stream;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
		end else if (o_load) begin
			o_vld_q <= 1'b1;
		end else if (emit.ready) begin
			o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_byte_q <= o_byte_d;
			o_last_q <= o_last_d;
		end
	end

	assign emit.valid         = o_vld_q;
	assign emit.out_byte      = o_byte_q;
	assign emit.last_of_burst = o_last_q;

	// A suppressed run is always a qualified one.
	assert property (@(posedge clk) disable iff (!arst_n) supp_q |-> qual_q)
		else $error("suppressed run without qualification");

	// The held run never outgrows the hold memory.
	assert property (@(posedge clk) disable iff (!arst_n) run_len_q <= THR_MAX)
		else $error("run length beyond hold depth");

	// The flush read pointer never passes the snapshot length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> (rd_addr_q <= flush_len_q))
		else $error("flush read pointer overran");

	// A flushing request moves the sequencer into the flush state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && flush_go) |=> (state_q == S_FLUSH))
		else $error("flush not started");

endmodule

`default_nettype wire
